// ----- hw/rtl/lru_key_value_cache_defines.svh -----
// ============================================================================
// LRU key/value cache assertion macros
// Shared property forms for the cache checkers.
// ============================================================================
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, muted while reset is low
`define LKVC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is low
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lkvc_pkg.sv -----
// ============================================================================
// LRU key/value cache package
// Sizes, field types and the lookup status struct shared by the cache RTL.
// ============================================================================
package lkvc_pkg;

    // Number of cache entries
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Fixed field widths
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 31;
    localparam int CAP_W  = 5;
    localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    // Operation codes carried on the input tuser
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0]        t_val;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [IDX_W-1:0]        t_rank;
    typedef logic [CNT_W-1:0]        t_cnt;

    // Result of the parallel key match and the oldest-entry search
    typedef struct packed {
        logic  hit;
        t_idx  hit_idx;
        t_rank hit_rank;
        t_val  hit_value;
        t_idx  old_idx;
    } t_lookup;

endpackage

// ----- hw/rtl/lkvc_lookup.sv -----
// ============================================================================
// LRU key/value cache lookup
// Compares the key against every valid entry and finds the least recent one.
// ============================================================================
module lkvc_lookup (
    input  lkvc_pkg::t_key    i_key,
    input  lkvc_pkg::t_key    i_keys   [lkvc_pkg::ENTRIES],
    input  lkvc_pkg::t_val    i_values [lkvc_pkg::ENTRIES],
    input  lkvc_pkg::t_rank   i_ranks  [lkvc_pkg::ENTRIES],
    input  logic [lkvc_pkg::ENTRIES-1:0] i_valid,
    input  lkvc_pkg::t_cnt    i_used_count,
    output lkvc_pkg::t_lookup o_lookup
);
    import lkvc_pkg::*;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] oldest_vec;
    t_cnt               oldest_rank;

    // Ranks of valid entries are a permutation of 0..used_count-1,
    // so the least recent entry is the one ranked used_count-1.
    assign oldest_rank = i_used_count - t_cnt'(1);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = i_valid[i] && (i_keys[i] == i_key);
            oldest_vec[i] = i_valid[i] && (t_cnt'(i_ranks[i]) == oldest_rank);
        end
    end

    // One-hot to index and AND-OR selection of the hit entry
    always_comb begin
        o_lookup = '0;
        o_lookup.hit = |match_vec;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                o_lookup.hit_idx   = o_lookup.hit_idx | t_idx'(i);
                o_lookup.hit_rank  = o_lookup.hit_rank | i_ranks[i];
                o_lookup.hit_value = o_lookup.hit_value | i_values[i];
            end
            if (oldest_vec[i]) begin
                o_lookup.old_idx = o_lookup.old_idx | t_idx'(i);
            end
        end
    end

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
// ============================================================================
// LRU key/value cache
// Fully associative get/set store with least-recently-used replacement.
// ============================================================================
// The cache takes one get or set request per clock and returns one result in
// the next cycle through an output register; a request is taken whenever that
// register is empty or being drained in the same cycle. The key is compared
// against all entries in parallel and the recency ranks of all entries are
// updated in the same cycle, so the next request already sees the new state.
// Entries fill in index order; once the configured capacity (0 acts as 1,
// above the entry count acts as the entry count) is in use, a new key set
// replaces the least recent entry. Lowering the capacity keeps the contents.
// No clearing pass is needed after reset.
module lru_key_value_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: cache_capacity
    input  logic        i_cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wr_data,
    // Request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] key, [62:32] value, [63] zero
    input  logic        i_s_axis_tuser,   // [0] mode (0 get, 1 set)
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [30:0] read_value, [31] zero
    output logic        o_m_axis_tuser    // [0] hit
);
    import lkvc_pkg::*;

    // Storage and control state
    t_key               r_keys   [ENTRIES];
    t_val               r_values [ENTRIES];
    t_rank              r_ranks  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_cnt               r_used_count;
    logic [CAP_W-1:0]   r_capacity;
    logic               r_out_valid;
    logic               r_out_hit;
    t_val               r_out_value;

    t_key    in_key;
    t_val    in_value;
    logic    in_mode;
    logic    accept;
    t_lookup lookup;

    logic [CMP_W-1:0] eff_cap;
    logic             do_fill;
    logic             do_evict;
    logic             do_touch;
    logic             do_write;
    t_idx             slot;
    t_cnt             age_limit;

    t_rank              n_ranks  [ENTRIES];
    logic [ENTRIES-1:0] n_valid;
    t_cnt               n_used_count;

    assign in_key   = i_s_axis_tdata[KEY_W-1:0];
    assign in_value = i_s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    assign in_mode  = i_s_axis_tuser;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    lkvc_lookup u_lookup (
        .i_key        (in_key),
        .i_keys       (r_keys),
        .i_values     (r_values),
        .i_ranks      (r_ranks),
        .i_valid      (r_valid),
        .i_used_count (r_used_count),
        .o_lookup     (lookup)
    );

    // Clamp the capacity register to 1..ENTRIES
    always_comb begin
        eff_cap = CMP_W'(r_capacity);
        if (r_capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end
    end

    // Decide what the request does to the store
    always_comb begin
        do_fill   = 1'b0;
        do_evict  = 1'b0;
        do_touch  = 1'b0;
        do_write  = 1'b0;
        slot      = lookup.hit_idx;
        age_limit = t_cnt'(lookup.hit_rank);
        if (accept) begin
            if (lookup.hit) begin
                do_touch = 1'b1;
                do_write = (in_mode == MODE_SET);
            end else if (in_mode == MODE_SET) begin
                do_touch = 1'b1;
                do_write = 1'b1;
                if (CMP_W'(r_used_count) < eff_cap) begin
                    do_fill   = 1'b1;
                    slot      = r_used_count[IDX_W-1:0];
                    age_limit = r_used_count;
                end else begin
                    do_evict  = 1'b1;
                    slot      = lookup.old_idx;
                    age_limit = r_used_count - t_cnt'(1);
                end
            end
        end
    end

    // Recency update: entries more recent than the touched one age by one
    always_comb begin
        n_valid      = r_valid;
        n_used_count = r_used_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_ranks[i] = r_ranks[i];
            if (do_touch) begin
                if (t_idx'(i) == slot) begin
                    n_ranks[i] = '0;
                end else if (r_valid[i] && (t_cnt'(r_ranks[i]) < age_limit)) begin
                    n_ranks[i] = r_ranks[i] + t_rank'(1);
                end
            end
        end
        if (do_fill) begin
            n_valid[slot] = 1'b1;
            n_used_count  = r_used_count + t_cnt'(1);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_used_count <= '0;
            r_capacity   <= CAP_W'(16);
            r_out_valid  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_ranks[i] <= '0;
            end
        end else begin
            r_valid      <= n_valid;
            r_used_count <= n_used_count;
            r_ranks      <= n_ranks;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Key and value storage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (do_write && (t_idx'(i) == slot)) begin
                r_values[i] <= in_value;
                if (do_fill || do_evict) begin
                    r_keys[i] <= in_key;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_hit   <= lookup.hit;
            r_out_value <= (lookup.hit && (in_mode == MODE_GET)) ? lookup.hit_value : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = {1'b0, r_out_value};

endmodule

// ----- hw/rtl/lkvc_checker.sv -----
// ============================================================================
// LRU key/value cache checker
// Port-level assertions on the cache, bound to the top level.
// ============================================================================
`include "lru_key_value_cache_defines.svh"

module lkvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic        o_m_axis_tuser
);
    import lkvc_pkg::*;

    logic in_xfer;
    logic set_xfer;
    logic get_xfer;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign set_xfer = in_xfer && (i_s_axis_tuser == MODE_SET);
    assign get_xfer = in_xfer && (i_s_axis_tuser == MODE_GET);

    // A stalled result stays offered
    `LKVC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")

    // Every request transfer shows a result in the next cycle
    `LKVC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_xfer, o_m_axis_tvalid, "no result after request transfer")

    // An empty output register never blocks requests
    `LKVC_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty output")

    // A get right after a set of the same key must hit
    `LKVC_ASSERT_NEXT(a_set_then_get_hits, i_clk, i_rst_n, get_xfer && $past(set_xfer) && (i_s_axis_tdata[KEY_W-1:0] == $past(i_s_axis_tdata[KEY_W-1:0])), o_m_axis_tuser, "get missed a key set the cycle before")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- dv/lru_key_value_cache_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// LRU key/value cache testbench
// Streams get/set requests through the cache with random idle and stall
// bursts. A behavioral LRU store predicts every result. Results are checked
// in order against it while the capacity register is stepped through its range.
// ============================================================================
module lru_key_value_cache_test;
    import lkvc_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 70;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic mode;
        t_key key;
        t_val value;
    } t_cache_req;

    typedef struct {
        logic hit;
        t_val read_value;
    } t_cache_rsp;

    // DUT ports
    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CAP_W-1:0] i_cfg_wr_data;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [63:0]      i_s_axis_tdata;   // [31:0] key, [62:32] value, [63] zero
    logic             i_s_axis_tuser;   // [0] mode
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [31:0]      o_m_axis_tdata;   // [30:0] read_value, [31] zero
    logic             o_m_axis_tuser;   // [0] hit

    // Shadow copy of the cache contents
    logic [CAP_W-1:0] shadow_capacity = 5'd16;
    t_key             line_key   [ENTRIES];
    t_val             line_val   [ENTRIES];
    bit               line_valid [ENTRIES] = '{default: 1'b0};
    int               line_age   [ENTRIES] = '{default: 0};
    int               lines_used = 0;

    // Traffic bookkeeping
    t_cache_req req_pending[$];
    t_cache_rsp lookup_due[$];
    t_cache_req drive_req;
    t_cache_req taken_req;
    t_cache_rsp due_rsp;
    bit         req_taken   = 1'b0;
    bit         idle_on     = 1'b1;
    int         send_gap    = 0;
    int         stall_left  = 0;
    int         reqs_queued = 0;
    int         reqs_sent   = 0;
    int         fail_count  = 0;
    int         quiet_cycles = 0;

    lru_key_value_cache DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Move one line to the front; every line newer than it ages by one
    function automatic void make_newest(int slot);
        int r;
        r = line_age[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && i != slot && line_age[i] < r)
                line_age[i]++;
        line_age[slot] = 0;
    endfunction

    // Apply one request to the shadow cache and return the result it gives
    function automatic t_cache_rsp cache_access(t_cache_req req);
        t_cache_rsp rsp;
        int         slot;
        int         cap;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && line_valid[i] && line_key[i] == req.key)
                slot = i;
        rsp.hit        = (slot >= 0);
        rsp.read_value = '0;
        if (req.mode == MODE_GET) begin
            if (slot >= 0) begin
                rsp.read_value = line_val[slot];
                make_newest(slot);
            end
        end else if (slot >= 0) begin
            line_val[slot] = req.value;
            make_newest(slot);
        end else begin
            // zero acts as one, anything above the entry count as the entry count
            cap = (shadow_capacity == 0) ? 1 :
                  (shadow_capacity > ENTRIES) ? ENTRIES : int'(shadow_capacity);
            if (lines_used < cap) begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!line_valid[i])
                        slot = i;
                line_valid[slot] = 1'b1;
                line_age[slot]   = lines_used;
                lines_used++;
            end else begin
                for (int i = 0; i < ENTRIES; i++)
                    if (line_valid[i] && (slot < 0 || line_age[i] > line_age[slot]))
                        slot = i;
            end
            line_key[slot] = req.key;
            line_val[slot] = req.value;
            make_newest(slot);
        end
        return rsp;
    endfunction

    task automatic push_req(logic mode, t_key key, t_val value);
        t_cache_req r;
        r.mode  = mode;
        r.key   = key;
        r.value = value;
        req_pending.push_back(r);
        reqs_queued++;
    endtask

    // Wait until every request is through and answered
    task automatic wait_drained();
        while (reqs_sent != reqs_queued || lookup_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Capacity writes only happen with the cache drained
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (3) @(negedge i_clk);
        i_cfg_wr_en     <= 1'b1;
        i_cfg_wr_data   <= cap;
        shadow_capacity = cap;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (req_pending.size() > 0) begin
                drive_req = req_pending[0];
                req_pending.delete(0);
                i_s_axis_tdata  <= {1'b0, drive_req.value, drive_req.key};
                i_s_axis_tuser  <= drive_req.mode;
                i_s_axis_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 10);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check results, predict from accepted requests, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (lookup_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result hit=%0b read_value=%h",
                                 $realtime, o_m_axis_tuser, o_m_axis_tdata[30:0]);
                end else begin
                    due_rsp = lookup_due[0];
                    lookup_due.delete(0);
                    if (o_m_axis_tuser !== due_rsp.hit ||
                        o_m_axis_tdata[30:0] !== due_rsp.read_value) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: result mismatch hit exp %0b got %0b, %s %h got %h",
                                     $realtime, due_rsp.hit, o_m_axis_tuser,
                                     "read_value exp", due_rsp.read_value,
                                     o_m_axis_tdata[30:0]);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                taken_req.mode  = i_s_axis_tuser;
                taken_req.key   = i_s_axis_tdata[31:0];
                taken_req.value = i_s_axis_tdata[62:32];
                lookup_due.push_back(cache_access(taken_req));
                req_taken = 1'b1;
                reqs_sent++;
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_key             key_pool[$];
        t_key             corner_keys[4];
        logic [CAP_W-1:0] phase_caps[8];
        int               cap_eff;
        int               pool_size;

        corner_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        phase_caps  = '{5'd31, 5'd1, 5'd17, 5'd5, 5'd16, 5'd3, 5'd0, 5'd8};
        phase_caps[6] = CAP_W'($urandom_range(0, 31));

        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = MODE_GET;
        i_m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty miss, corner keys and values, overwrite, ignored value
        push_req(MODE_GET, 32'h0000_0000, 31'h0);
        push_req(MODE_SET, 32'h8000_0000, 31'h7FFF_FFFF);
        push_req(MODE_SET, 32'h7FFF_FFFF, 31'h0);
        push_req(MODE_SET, 32'h0000_0000, 31'h1);
        push_req(MODE_SET, 32'hFFFF_FFFF, 31'h5555_5555);
        push_req(MODE_GET, 32'h8000_0000, 31'h0);
        push_req(MODE_GET, 32'h7FFF_FFFF, 31'h0);
        push_req(MODE_GET, 32'h1234_5678, 31'h0);
        push_req(MODE_SET, 32'h0000_0000, 31'h2AAA_AAAA);
        push_req(MODE_GET, 32'h0000_0000, 31'h0);
        push_req(MODE_GET, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

        // Capacity lowered below the fill level: new keys replace the oldest
        write_capacity(5'd2);
        push_req(MODE_SET, 32'h0000_1111, 31'h1);
        push_req(MODE_GET, 32'h8000_0000, 31'h0);
        push_req(MODE_GET, 32'h7FFF_FFFF, 31'h0);
        push_req(MODE_GET, 32'hFFFF_FFFF, 31'h0);
        push_req(MODE_SET, 32'h0000_2222, 31'h2);
        push_req(MODE_GET, 32'h0000_1111, 31'h0);

        // Capacity zero behaves as one
        write_capacity(5'd0);
        push_req(MODE_SET, 32'h0000_3333, 31'h3);
        push_req(MODE_GET, 32'h0000_3333, 31'h0);
        push_req(MODE_GET, 32'h0000_2222, 31'h0);
        push_req(MODE_GET, 32'h0000_1111, 31'h0);

        // Random phases, one capacity each, last one with no idling
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            idle_on = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
            cap_eff = (phase_caps[p] == 0) ? 1 :
                      (phase_caps[p] > ENTRIES) ? ENTRIES : int'(phase_caps[p]);
            pool_size = cap_eff + $urandom_range(1, 6);
            key_pool.delete();
            for (int k = 0; k < pool_size; k++)
                key_pool.push_back(($urandom_range(0, 3) == 0) ?
                                   corner_keys[$urandom_range(0, 3)] : t_key'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_req(1'($urandom_range(0, 1)),
                         ($urandom_range(0, 9) == 0) ?
                             t_key'($urandom) : key_pool[$urandom_range(0, pool_size - 1)],
                         t_val'($urandom));
        end

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
